@@ hw/rtl/assert_macros.svh @@
// assertion macros for the heap checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap checker: implication failed");

// next-cycle implication, off during reset
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap checker: next-cycle implication failed");

// next-cycle implication, also checked during reset
`define ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("heap checker: reset behavior failed");

`endif

@@ hw/rtl/imh_pkg.sv @@
package imh_pkg;

  localparam int ENTRIES  = 32;
  localparam int KEY_BITS = 16;
  localparam int SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  // fixed field widths of the channels
  localparam int KIND_W = 2;
  localparam int IDX_W  = 5;
  localparam int KEY_W  = 16;
  localparam int OCC_W  = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_t;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    slot_t id;
    key_t  key;
  } hslot_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_PUSH_SKIP,
    OP_PUSH_OLD,
    OP_PUSH_NEW,
    OP_EMPTY,
    OP_PEEK,
    OP_POP,
    OP_SU_RD,
    OP_SU_MOVE,
    OP_SD_RD,
    OP_SD_MOVE,
    OP_FIN,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic idx_ok;
    logic present;
    logic cnt_zero;
    logic hole_zero;
    logic up_move;
    logic sd_leaf;
    logic sd_move;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/imh_in_if.sv @@
interface imh_in_if;
  import imh_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  entry_index;
  logic [KEY_W-1:0]  entry_key;

  modport source (output valid, output kind, output entry_index, output entry_key,
                  input ready);
  modport sink (input valid, input kind, input entry_index, input entry_key,
                output ready);
endinterface

@@ hw/rtl/imh_out_if.sv @@
interface imh_out_if;
  import imh_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_index;
  logic [KEY_W-1:0] result_key;
  logic [OCC_W-1:0] occupancy;
  logic             empty_flag;

  modport source (output valid, output result_index, output result_key,
                  output occupancy, output empty_flag, input ready);
  modport sink (input valid, input result_index, input result_key,
                input occupancy, input empty_flag, output ready);
endinterface

@@ hw/rtl/indexed_max_heap_top.sv @@
// indexed max-heap: one word in flight, next word taken the cycle after its result is loaded
// after acceptance a word is decoded; a peek, an empty pop or a skipped push goes to done,
// a push or pop walks the heap level by level until a compare stops it or it reaches an end,
// then writes its slot at fin; done loads the result when the output is free, else waits
// reset (rst_n low, synchronous) empties the heap and clears the output valid
module indexed_max_heap_top (
  input  logic      clk,
  input  logic      rst_n,
  imh_in_if.sink    in_ch,
  imh_out_if.source out_ch
);
  import imh_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  imh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  imh_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_ch.kind),
    .in_entry_index   (in_ch.entry_index),
    .in_entry_key     (in_ch.entry_key),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_result_index (out_ch.result_index),
    .out_result_key   (out_ch.result_key),
    .out_occupancy    (out_ch.occupancy),
    .out_empty_flag   (out_ch.empty_flag)
  );

endmodule

@@ hw/rtl/imh_ctrl.sv @@
module imh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  imh_pkg::dp_stat_t stat,
  output logic              in_ready,
  output imh_pkg::dp_cmd_t  cmd
);
  import imh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SU_CHECK,
    S_SU_CMP,
    S_SD_CHECK,
    S_SD_CMP,
    S_FIN,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.is_push && !stat.idx_ok) begin
          cmd.op    = OP_PUSH_SKIP;
          state_nxt = S_DONE;
        end else if (stat.is_push && stat.present) begin
          cmd.op    = OP_PUSH_OLD;
          state_nxt = S_SU_CHECK;
        end else if (stat.is_push) begin
          cmd.op    = OP_PUSH_NEW;
          state_nxt = S_SU_CHECK;
        end else if (stat.cnt_zero) begin
          cmd.op    = OP_EMPTY;
          state_nxt = S_DONE;
        end else if (stat.is_pop) begin
          cmd.op    = OP_POP;
          state_nxt = S_SD_CHECK;
        end else begin
          cmd.op    = OP_PEEK;
          state_nxt = S_DONE;
        end
      end
      S_SU_CHECK: begin
        if (stat.hole_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_SU_RD;
          state_nxt = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        if (stat.up_move) begin
          cmd.op    = OP_SU_MOVE;
          state_nxt = S_SU_CHECK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SD_CHECK: begin
        if (stat.sd_leaf) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_SD_RD;
          state_nxt = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        if (stat.sd_move) begin
          cmd.op    = OP_SD_MOVE;
          state_nxt = S_SD_CHECK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/imh_dp.sv @@
module imh_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  imh_pkg::dp_cmd_t              cmd,
  output imh_pkg::dp_stat_t             stat,
  input  logic [imh_pkg::KIND_W-1:0]    in_kind,
  input  logic [imh_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [imh_pkg::KEY_W-1:0]     in_entry_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [imh_pkg::IDX_W-1:0]     out_result_index,
  output logic [imh_pkg::KEY_W-1:0]     out_result_key,
  output logic [imh_pkg::OCC_W-1:0]     out_occupancy,
  output logic                          out_empty_flag
);
  import imh_pkg::*;

  // heap slots carry entry id and key together
  hslot_t heap_mem [ENTRIES];
  slot_t  pos_mem  [ENTRIES];

  logic [ENTRIES-1:0] present_r;
  cnt_t               count_r;
  logic [KIND_W-1:0]  kind_r;
  logic [IDX_W-1:0]   idx_r;
  hslot_t             cur_r;
  slot_t              hole_r;
  hslot_t             rd_a_r;
  hslot_t             rd_b_r;
  slot_t              pos_rd_r;
  logic [IDX_W-1:0]   res_idx_r;
  logic [KEY_W-1:0]   res_key_r;
  logic               res_empty_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [KEY_W-1:0]   out_key_r;
  logic [OCC_W-1:0]   out_occ_r;
  logic               out_empty_r;

  logic [CNT_W:0] l_pos;
  logic [CNT_W:0] r_pos;
  logic           take_r;
  hslot_t         child;
  slot_t          child_slot;
  slot_t          parent;
  slot_t          rd_a_addr;
  slot_t          rd_b_addr;
  logic           heap_we;
  hslot_t         heap_wd;
  logic           pos_we;
  slot_t          pos_wa;

  // child and parent slots of the hole
  assign l_pos      = (CNT_W + 1)'({hole_r, 1'b1});
  assign r_pos      = l_pos + (CNT_W + 1)'(1);
  assign take_r     = (r_pos < {1'b0, count_r}) && (rd_a_r.key < rd_b_r.key);
  assign child      = take_r ? rd_b_r : rd_a_r;
  assign child_slot = take_r ? SLOT_W'(r_pos) : SLOT_W'(l_pos);
  assign parent     = (hole_r - SLOT_W'(1)) >> 1;

  always_comb begin
    unique case (cmd.op)
      OP_SU_RD: begin
        rd_a_addr = parent;
        rd_b_addr = SLOT_W'(count_r - CNT_W'(1));
      end
      OP_SD_RD: begin
        rd_a_addr = SLOT_W'(l_pos);
        rd_b_addr = SLOT_W'(r_pos);
      end
      default: begin
        rd_a_addr = '0;
        rd_b_addr = SLOT_W'(count_r - CNT_W'(1));
      end
    endcase
  end

  always_comb begin
    heap_we = 1'b0;
    heap_wd = cur_r;
    pos_we  = 1'b0;
    pos_wa  = cur_r.id;
    unique case (cmd.op)
      OP_SU_MOVE: begin
        heap_we = 1'b1;
        heap_wd = rd_a_r;
        pos_we  = 1'b1;
        pos_wa  = rd_a_r.id;
      end
      OP_SD_MOVE: begin
        heap_we = 1'b1;
        heap_wd = child;
        pos_we  = 1'b1;
        pos_wa  = child.id;
      end
      OP_FIN: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[hole_r] <= heap_wd;
    end
    if (pos_we) begin
      pos_mem[pos_wa] <= hole_r;
    end
    rd_a_r   <= heap_mem[rd_a_addr];
    rd_b_r   <= heap_mem[rd_b_addr];
    pos_rd_r <= pos_mem[SLOT_W'(in_entry_index)];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_PUSH_NEW: begin
          present_r[cur_r.id] <= 1'b1;
          count_r             <= count_r + CNT_W'(1);
        end
        OP_POP: begin
          present_r[rd_a_r.id] <= 1'b0;
          count_r              <= count_r - CNT_W'(1);
        end
        OP_EMIT: begin
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        kind_r     <= in_kind;
        idx_r      <= in_entry_index;
        cur_r.id   <= SLOT_W'(in_entry_index);
        cur_r.key  <= KEY_BITS'(in_entry_key);
      end
      OP_PUSH_SKIP: begin
        res_idx_r   <= idx_r;
        res_key_r   <= KEY_W'(cur_r.key);
        res_empty_r <= 1'b0;
      end
      OP_PUSH_OLD: begin
        res_idx_r   <= idx_r;
        res_key_r   <= KEY_W'(cur_r.key);
        res_empty_r <= 1'b0;
        hole_r      <= pos_rd_r;
      end
      OP_PUSH_NEW: begin
        res_idx_r   <= idx_r;
        res_key_r   <= KEY_W'(cur_r.key);
        res_empty_r <= 1'b0;
        hole_r      <= SLOT_W'(count_r);
      end
      OP_EMPTY: begin
        res_idx_r   <= '0;
        res_key_r   <= '0;
        res_empty_r <= 1'b1;
      end
      OP_PEEK: begin
        res_idx_r   <= IDX_W'(rd_a_r.id);
        res_key_r   <= KEY_W'(rd_a_r.key);
        res_empty_r <= 1'b0;
      end
      OP_POP: begin
        res_idx_r   <= IDX_W'(rd_a_r.id);
        res_key_r   <= KEY_W'(rd_a_r.key);
        res_empty_r <= 1'b0;
        cur_r       <= rd_b_r;
        hole_r      <= '0;
      end
      OP_SU_MOVE: begin
        hole_r <= parent;
      end
      OP_SD_MOVE: begin
        hole_r <= child_slot;
      end
      OP_EMIT: begin
        out_idx_r   <= res_idx_r;
        out_key_r   <= res_key_r;
        out_occ_r   <= OCC_W'(count_r);
        out_empty_r <= res_empty_r;
      end
      default: ;
    endcase
  end

  assign stat.is_push   = (kind_r == KIND_PUSH);
  assign stat.is_pop    = (kind_r == KIND_POP);
  assign stat.idx_ok    = (int'(idx_r) < ENTRIES);
  assign stat.present   = present_r[cur_r.id];
  assign stat.cnt_zero  = (count_r == '0);
  assign stat.hole_zero = (hole_r == '0);
  assign stat.up_move   = (rd_a_r.key < cur_r.key);
  assign stat.sd_leaf   = (l_pos >= {1'b0, count_r});
  assign stat.sd_move   = (cur_r.key < child.key);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_result_key   = out_key_r;
  assign out_occupancy    = out_occ_r;
  assign out_empty_flag   = out_empty_r;

endmodule

@@ hw/rtl/imh_checker.sv @@
`include "assert_macros.svh"

module imh_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [imh_pkg::IDX_W-1:0] out_result_index,
  input logic [imh_pkg::KEY_W-1:0] out_result_key,
  input logic [imh_pkg::OCC_W-1:0] out_occupancy,
  input logic                      out_empty_flag
);
  import imh_pkg::*;

  localparam int WORD_W = IDX_W + KEY_W + OCC_W + 1;

  logic [WORD_W-1:0] out_word;
  logic              fields_zero;

  assign out_word    = {out_result_index, out_result_key, out_occupancy, out_empty_flag};
  assign fields_zero = (out_occupancy == '0) && (out_result_index == '0) &&
                       (out_result_key == '0);

  `ASSERT_NXT_RST(a_reset_clears_out, !rst_n, !out_valid)
  `ASSERT_NXT(a_stall_holds_valid, out_valid && !out_ready, out_valid)
  `ASSERT_NXT(a_stall_holds_word, out_valid && !out_ready, $stable(out_word))
  `ASSERT_IMP(a_empty_word_zero, out_valid && out_empty_flag, fields_zero)
  `ASSERT_IMP(a_occupancy_bound, out_valid, int'(out_occupancy) <= ENTRIES)

endmodule

bind indexed_max_heap_top imh_checker u_imh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_index (out_ch.result_index),
  .out_result_key   (out_ch.result_key),
  .out_occupancy    (out_ch.occupancy),
  .out_empty_flag   (out_ch.empty_flag)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import imh_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1200;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int CALM_FROM = 4000;
  localparam int CALM_TO = 7000;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  key;
    bit                wait_drain;
  } heap_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [OCC_W-1:0] occ;
    logic             empty;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n;

  imh_in_if  in_ch();
  imh_out_if out_ch();

  indexed_max_heap_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  heap_req_t    pending_words[$];
  heap_result_t results_due[$];

  // heap shadow
  logic [IDX_W-1:0] slot_entry [ENTRIES];
  int               entry_slot [ENTRIES];
  bit               entry_live [ENTRIES];
  logic [KEY_W-1:0] key_of [ENTRIES];
  int               live_count = 0;

  int  cycle_count = 0;
  bit  in_fired = 1'b0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  push_words = 0;
  int  pop_words = 0;
  int  peek_words = 0;
  int  empty_results = 0;
  int  full_hits = 0;
  int  peak_occ = 0;

  wire calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  function automatic void swap_heap_slots(int a, int b);
    logic [IDX_W-1:0] ea;
    logic [IDX_W-1:0] eb;
    ea = slot_entry[a];
    eb = slot_entry[b];
    slot_entry[a] = eb;
    slot_entry[b] = ea;
    entry_slot[eb] = a;
    entry_slot[ea] = b;
  endfunction

  function automatic heap_result_t apply_heap_op(logic [KIND_W-1:0] k, logic [IDX_W-1:0] idx,
                                                 logic [KEY_W-1:0] key);
    heap_result_t r;
    logic [IDX_W-1:0] top;
    int j;
    int p;
    int c;
    bit done;
    r = '0;
    if (k == KIND_PUSH) begin
      r.idx = idx;
      r.key = key;
      key_of[idx] = key;
      if (!entry_live[idx]) begin
        slot_entry[live_count] = idx;
        entry_slot[idx] = live_count;
        entry_live[idx] = 1'b1;
        live_count++;
      end
      j = entry_slot[idx];
      done = 1'b0;
      while (j > 0 && !done) begin
        p = (j - 1) / 2;
        if (key_of[slot_entry[p]] < key_of[slot_entry[j]]) begin
          swap_heap_slots(p, j);
          j = p;
        end else begin
          done = 1'b1;
        end
      end
    end else if (live_count == 0) begin
      r.empty = 1'b1;
    end else begin
      top = slot_entry[0];
      r.idx = top;
      r.key = key_of[top];
      if (k == KIND_POP) begin
        entry_live[top] = 1'b0;
        live_count--;
        if (live_count > 0) begin
          slot_entry[0] = slot_entry[live_count];
          entry_slot[slot_entry[0]] = 0;
          j = 0;
          done = 1'b0;
          while (!done) begin
            c = 2 * j + 1;
            if (c >= live_count) begin
              done = 1'b1;
            end else begin
              if (c + 1 < live_count && key_of[slot_entry[c]] < key_of[slot_entry[c + 1]]) begin
                c++;
              end
              if (key_of[slot_entry[j]] >= key_of[slot_entry[c]]) begin
                done = 1'b1;
              end else begin
                swap_heap_slots(j, c);
                j = c;
              end
            end
          end
        end
      end
    end
    r.occ = OCC_W'(live_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  task automatic queue_word(input logic [KIND_W-1:0] k, input int idx, input int key,
                            input bit hold = 1'b0);
    heap_req_t w;
    w.kind = k;
    w.idx = IDX_W'(idx);
    w.key = KEY_W'(key);
    w.wait_drain = hold;
    pending_words.push_back(w);
  endtask

  // keys lean toward ties and extremes part of the time
  function automatic int pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 65535);
    if (r < 80) return $urandom_range(0, 7);
    if (r < 90) return ($urandom_range(0, 1) != 0) ? 65535 : 0;
    return $urandom_range(65520, 65535);
  endfunction

  // driver: new word at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 20) &&
          !(pending_words[0].wait_drain && results_due.size() != 0)) begin
        in_ch.kind        <= pending_words[0].kind;
        in_ch.entry_index <= pending_words[0].idx;
        in_ch.entry_key   <= pending_words[0].key;
        in_ch.valid       <= 1'b1;
        void'(pending_words.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    heap_result_t got;
    heap_result_t want;
    cycle_count <= cycle_count + 1;
    in_fired <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.result_index, out_ch.result_key, out_ch.occupancy, out_ch.empty_flag};
        results_seen++;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result word idx %0d key %h occ %0d empty %b",
                                    got.idx, got.key, got.occ, got.empty));
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf(
              "result %0d: exp idx %0d key %h occ %0d empty %b, got idx %0d key %h occ %0d empty %b",
              results_seen, want.idx, want.key, want.occ, want.empty,
              got.idx, got.key, got.occ, got.empty));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = apply_heap_op(in_ch.kind, in_ch.entry_index, in_ch.entry_key);
        results_due.push_back(want);
        if (in_ch.kind == KIND_PUSH) push_words++;
        else if (in_ch.kind == KIND_POP) pop_words++;
        else peek_words++;
        if (want.empty) empty_results++;
        if (want.occ == ENTRIES) full_hits++;
        if (want.occ > peak_occ) peak_occ = want.occ;
      end
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) @(posedge clk);
    $display("run stopped at the cycle limit with %0d results outstanding", results_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int n;
    int t;
    int r;
    int perm [ENTRIES];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_PUSH;
    in_ch.entry_index = '0;
    in_ch.entry_key = '0;
    out_ch.ready = 1'b0;

    // empty heap, ties, lowered and raised keys, unused kind
    queue_word(KIND_PEEK, 0, 0);
    queue_word(KIND_POP, 0, 0);
    queue_word(KIND_SPARE, 0, 0);
    queue_word(KIND_PUSH, 31, 65535);
    queue_word(KIND_PUSH, 0, 0);
    queue_word(KIND_PUSH, 5, 65535);
    queue_word(KIND_PEEK, 0, 0);
    queue_word(KIND_SPARE, 17, 1234);
    queue_word(KIND_PUSH, 31, 0);
    queue_word(KIND_PEEK, 0, 0);
    queue_word(KIND_PUSH, 0, 1);
    queue_word(KIND_PUSH, 10, 16'haaaa);
    queue_word(KIND_PUSH, 21, 16'h5555);
    queue_word(KIND_POP, 0, 0, 1'b1);
    queue_word(KIND_POP, 0, 0);
    queue_word(KIND_POP, 0, 0);
    queue_word(KIND_POP, 0, 0);
    queue_word(KIND_POP, 0, 0);
    queue_word(KIND_POP, 0, 0);
    queue_word(KIND_PEEK, 0, 0);

    n = pending_words.size() + RANDOM_WORDS;
    while (pending_words.size() < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 40)) begin
            queue_word(KIND_PUSH, $urandom_range(0, ENTRIES - 1), pick_key(),
                       $urandom_range(0, 199) == 0);
          end
        end
        3, 4: begin
          repeat ($urandom_range(1, 36)) begin
            queue_word(($urandom_range(0, 7) == 0) ? KIND_PEEK : KIND_POP, 0, 0);
          end
        end
        5: begin
          // fill every entry in random order, then follow with ENTRIES + 1 words, mostly pops, some peeks
          for (int i = 0; i < ENTRIES; i++) perm[i] = i;
          for (int i = ENTRIES - 1; i > 0; i--) begin
            r = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[r];
            perm[r] = t;
          end
          for (int i = 0; i < ENTRIES; i++) queue_word(KIND_PUSH, perm[i], pick_key());
          repeat (ENTRIES + 1) begin
            queue_word(($urandom_range(0, 9) == 0) ? KIND_PEEK : KIND_POP,
                       $urandom_range(0, ENTRIES - 1), $urandom_range(0, 65535));
          end
        end
        default: begin
          repeat ($urandom_range(1, 30)) begin
            r = $urandom_range(0, 99);
            queue_word((r < 45) ? KIND_PUSH : (r < 80) ? KIND_POP :
                       (r < 92) ? KIND_PEEK : KIND_SPARE,
                       $urandom_range(0, ENTRIES - 1), pick_key(), $urandom_range(0, 199) == 0);
          end
        end
      endcase
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_ch.valid || results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (results_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", results_due.size()));
    end
    $display("covered %0d words: %0d push, %0d pop, %0d peek or unused kind; %0d results checked",
             push_words + pop_words + peek_words, push_words, pop_words, peek_words, results_seen);
    $display("empty-heap results %0d, peak occupancy %0d, full heap seen %0d times",
             empty_results, peak_occ, full_hits);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
